>>> src/assert_macros.svh
// ---------------------------------------------------------------------------
// assert_macros.svh
// Concurrent assertion helpers, compiled out for synthesis.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// prop must hold at every clock edge outside reset
`define TTCW_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// expr must never be true outside reset
`define TTCW_NEVER(lbl, clk, rst_n, expr, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) else $error(msg);

`else

`define TTCW_ASSERT(lbl, clk, rst_n, prop, msg)
`define TTCW_NEVER(lbl, clk, rst_n, expr, msg)

`endif

`endif

>>> src/ttcw_pkg.sv
// ---------------------------------------------------------------------------
// ttcw_pkg
// Shared types and constants of the text terminal character writer.
// ---------------------------------------------------------------------------
package ttcw_pkg;

    localparam int SCREEN_COLS_DEF = 80;
    localparam int SCREEN_ROWS_DEF = 25;

    localparam logic [7:0] CH_NEWLINE   = 8'd10;
    localparam logic [7:0] CH_CR        = 8'd13;
    localparam logic [7:0] CH_TAB       = 8'd9;
    localparam logic [7:0] CH_BACKSPACE = 8'd8;
    localparam logic [7:0] BLANK_CHAR   = 8'h20;

    localparam logic [3:0] CELL_FG = 4'd7;
    localparam logic [3:0] CELL_BG = 4'd0;

    typedef enum logic [1:0] {
        OP_PUT   = 2'd0,
        OP_SET   = 2'd1,
        OP_CLEAR = 2'd2,
        OP_READ  = 2'd3
    } op_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_EXEC,
        ST_READ,
        ST_BLANK
    } state_t;

endpackage

>>> src/text_terminal_char_writer_core.sv
// ---------------------------------------------------------------------------
// text_terminal_char_writer_core
// Character-cell text screen with cursor, backed by one screen memory.
// ---------------------------------------------------------------------------
// Usage:
//   A command transaction is taken at a rising edge with start high and busy
//   low: opcode, char_code, col and row are sampled there. Exactly one result
//   transaction follows, shown for one cycle with done high; the receiver
//   cannot stall, so it must take it in that cycle.
// Sequence (accept to done):
//   put char, set cursor, clear: the command runs in the EXEC state, which
//   registers done; read cell adds a READ state for the registered memory read.
// Acceptance: a new command is taken only once busy is low again. A put char
//   that scrolls keeps busy high while the new bottom row is blanked, one cell
//   per cycle; clear keeps it high while all SCREEN_COLS*SCREEN_ROWS cells are
//   blanked.
// Scrolling does not move data: a top-row pointer rotates, and only the row
//   that becomes the bottom row is rewritten with spaces.
// Reset: cursor and top pointer go to 0, then a clearing pass writes spaces
//   to all SCREEN_COLS*SCREEN_ROWS cells, one per cycle, with busy high.
// ---------------------------------------------------------------------------
module text_terminal_char_writer_core #(
    parameter int SCREEN_COLS = ttcw_pkg::SCREEN_COLS_DEF,
    parameter int SCREEN_ROWS = ttcw_pkg::SCREEN_ROWS_DEF
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    output logic              busy,
    input  logic [1:0]        opcode,
    input  logic [7:0]        char_code,
    input  logic signed [9:0] col,
    input  logic signed [9:0] row,
    output logic              done,
    output logic [7:0]        cell_char,
    output logic [3:0]        cell_fg,
    output logic [3:0]        cell_bg,
    output logic [7:0]        cursor_col_out,
    output logic [7:0]        cursor_row_out,
    output logic              scrolled
);

`include "assert_macros.svh"

    localparam int CELLS = SCREEN_COLS * SCREEN_ROWS;
    localparam int AW    = $clog2(CELLS);

    // screen memory, one byte per cell, physical row-major order
    logic [7:0]    mem [CELLS];
    logic [7:0]    mem_rdata;
    logic          mem_we;
    logic          mem_re;
    logic [AW-1:0] mem_addr;
    logic [7:0]    mem_wdata;

    ttcw_pkg::state_t state_reg, state_next;
    ttcw_pkg::op_t    op_reg, op_next;
    logic [7:0]    char_reg, char_next;
    logic [7:0]    tcol_reg, tcol_next;      // target column of the command
    logic [7:0]    phys_reg, phys_next;      // physical row of the put or read target
    logic          in_range_reg, in_range_next;
    logic [7:0]    cursor_col_reg, cursor_col_next;
    logic [7:0]    cursor_line_reg, cursor_line_next;
    logic [7:0]    top_reg, top_next;        // physical row shown as row 0
    logic [AW-1:0] blank_addr_reg, blank_addr_next;
    logic [AW-1:0] blank_end_reg, blank_end_next;
    logic          done_reg, done_next;
    logic [7:0]    cell_char_reg, cell_char_next;
    logic          scrolled_reg, scrolled_next;

    // accept-side decode
    logic [7:0] line_sel;
    logic [8:0] phys_sum;
    logic       col_ok;
    logic       row_ok;

    // put char arithmetic
    logic [8:0]    col_plus1;
    logic [8:0]    col_tab;
    logic          inc_line;
    logic [AW-1:0] cell_addr;
    logic [AW-1:0] top_base;

    assign col_ok = !col[9] && (col[8:0] < 9'(SCREEN_COLS));
    assign row_ok = !row[9] && (row[8:0] < 9'(SCREEN_ROWS));

    assign line_sel = (ttcw_pkg::op_t'(opcode) == ttcw_pkg::OP_READ) ? row[7:0]
                                                                     : cursor_line_reg;
    assign phys_sum = {1'b0, line_sel} + {1'b0, top_reg};

    assign col_plus1 = {1'b0, cursor_col_reg} + 9'd1;
    assign col_tab   = ({1'b0, cursor_col_reg} + 9'd8) & ~9'd7;

    assign cell_addr = AW'(32'(phys_reg) * SCREEN_COLS + 32'(tcol_reg));
    assign top_base  = AW'(32'(top_reg) * SCREEN_COLS);

    // next state and datapath control
    always_comb
    begin
        state_next       = state_reg;
        op_next          = op_reg;
        char_next        = char_reg;
        tcol_next        = tcol_reg;
        phys_next        = phys_reg;
        in_range_next    = in_range_reg;
        cursor_col_next  = cursor_col_reg;
        cursor_line_next = cursor_line_reg;
        top_next         = top_reg;
        blank_addr_next  = blank_addr_reg;
        blank_end_next   = blank_end_reg;
        done_next        = 1'b0;
        cell_char_next   = cell_char_reg;
        scrolled_next    = 1'b0;
        mem_we           = 1'b0;
        mem_re           = 1'b0;
        mem_addr         = cell_addr;
        mem_wdata        = char_reg;
        inc_line         = 1'b0;

        case (state_reg)
            ttcw_pkg::ST_IDLE:
            begin
                if (start)
                begin
                    op_next       = ttcw_pkg::op_t'(opcode);
                    char_next     = char_code;
                    in_range_next = col_ok && row_ok;
                    tcol_next     = (ttcw_pkg::op_t'(opcode) == ttcw_pkg::OP_PUT)
                                    ? cursor_col_reg : col[7:0];
                    if (phys_sum >= 9'(SCREEN_ROWS))
                        phys_next = 8'(phys_sum - 9'(SCREEN_ROWS));
                    else
                        phys_next = phys_sum[7:0];
                    state_next    = ttcw_pkg::ST_EXEC;
                end
            end

            ttcw_pkg::ST_EXEC:
            begin
                cell_char_next = 8'd0;
                done_next      = 1'b1;
                state_next     = ttcw_pkg::ST_IDLE;
                case (op_reg)
                    ttcw_pkg::OP_PUT:
                    begin
                        case (char_reg)
                            ttcw_pkg::CH_NEWLINE:
                            begin
                                cursor_col_next = 8'd0;
                                inc_line        = 1'b1;
                            end
                            ttcw_pkg::CH_CR:
                            begin
                                cursor_col_next = 8'd0;
                            end
                            ttcw_pkg::CH_TAB:
                            begin
                                if (col_tab >= 9'(SCREEN_COLS))
                                begin
                                    cursor_col_next = 8'd0;
                                    inc_line        = 1'b1;
                                end
                                else
                                    cursor_col_next = col_tab[7:0];
                            end
                            ttcw_pkg::CH_BACKSPACE:
                            begin
                                if (cursor_col_reg != 8'd0)
                                    cursor_col_next = cursor_col_reg - 8'd1;
                            end
                            default:
                            begin
                                mem_we = 1'b1;
                                if (col_plus1 >= 9'(SCREEN_COLS))
                                begin
                                    cursor_col_next = 8'd0;
                                    inc_line        = 1'b1;
                                end
                                else
                                    cursor_col_next = col_plus1[7:0];
                            end
                        endcase
                        if (inc_line)
                        begin
                            if (cursor_line_reg == 8'(SCREEN_ROWS - 1))
                            begin
                                // rotate: the old top row becomes the blank bottom row
                                scrolled_next   = 1'b1;
                                top_next        = (top_reg == 8'(SCREEN_ROWS - 1))
                                                  ? 8'd0 : top_reg + 8'd1;
                                blank_addr_next = top_base;
                                blank_end_next  = top_base + AW'(SCREEN_COLS - 1);
                                state_next      = ttcw_pkg::ST_BLANK;
                            end
                            else
                                cursor_line_next = cursor_line_reg + 8'd1;
                        end
                    end
                    ttcw_pkg::OP_SET:
                    begin
                        if (in_range_reg)
                        begin
                            cursor_col_next  = tcol_reg;
                            cursor_line_next = phys_reg;   // overwritten below
                        end
                    end
                    ttcw_pkg::OP_CLEAR:
                    begin
                        cursor_col_next  = 8'd0;
                        cursor_line_next = 8'd0;
                        top_next         = 8'd0;
                        blank_addr_next  = '0;
                        blank_end_next   = AW'(CELLS - 1);
                        state_next       = ttcw_pkg::ST_BLANK;
                    end
                    ttcw_pkg::OP_READ:
                    begin
                        mem_re     = in_range_reg;
                        done_next  = 1'b0;
                        state_next = ttcw_pkg::ST_READ;
                    end
                    default:
                    begin
                        state_next = ttcw_pkg::ST_IDLE;
                    end
                endcase
            end

            ttcw_pkg::ST_READ:
            begin
                cell_char_next = in_range_reg ? mem_rdata : ttcw_pkg::BLANK_CHAR;
                done_next      = 1'b1;
                state_next     = ttcw_pkg::ST_IDLE;
            end

            ttcw_pkg::ST_BLANK:
            begin
                mem_we    = 1'b1;
                mem_addr  = blank_addr_reg;
                mem_wdata = ttcw_pkg::BLANK_CHAR;
                if (blank_addr_reg == blank_end_reg)
                    state_next = ttcw_pkg::ST_IDLE;
                else
                    blank_addr_next = blank_addr_reg + AW'(1);
            end

            default:
            begin
                state_next = ttcw_pkg::ST_IDLE;
            end
        endcase
    end

    // set cursor takes the logical row, not the physical one
    logic [7:0] row_line_reg;
    logic [7:0] set_line;
    assign set_line = (state_reg == ttcw_pkg::ST_EXEC && op_reg == ttcw_pkg::OP_SET
                       && in_range_reg) ? row_line_reg : cursor_line_next;

    always_ff @(posedge clk)
    begin
        if (state_reg == ttcw_pkg::ST_IDLE && start)
            row_line_reg <= row[7:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= ttcw_pkg::ST_BLANK;
            cursor_col_reg  <= 8'd0;
            cursor_line_reg <= 8'd0;
            top_reg         <= 8'd0;
            blank_addr_reg  <= '0;
            blank_end_reg   <= AW'(CELLS - 1);
            done_reg        <= 1'b0;
            scrolled_reg    <= 1'b0;
        end
        else
        begin
            state_reg       <= state_next;
            cursor_col_reg  <= cursor_col_next;
            cursor_line_reg <= set_line;
            top_reg         <= top_next;
            blank_addr_reg  <= blank_addr_next;
            blank_end_reg   <= blank_end_next;
            done_reg        <= done_next;
            scrolled_reg    <= scrolled_next;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        op_reg        <= op_next;
        char_reg      <= char_next;
        tcol_reg      <= tcol_next;
        phys_reg      <= phys_next;
        in_range_reg  <= in_range_next;
        cell_char_reg <= cell_char_next;
    end

    // screen memory, single port, registered read
    always_ff @(posedge clk)
    begin
        if (mem_we)
            mem[mem_addr] <= mem_wdata;
        if (mem_re)
            mem_rdata <= mem[mem_addr];
    end

    assign busy           = (state_reg != ttcw_pkg::ST_IDLE);
    assign done           = done_reg;
    assign cell_char      = cell_char_reg;
    assign cell_fg        = ttcw_pkg::CELL_FG;
    assign cell_bg        = ttcw_pkg::CELL_BG;
    assign cursor_col_out = cursor_col_reg;
    assign cursor_row_out = cursor_line_reg;
    assign scrolled       = scrolled_reg;

    // results are never back to back
    `TTCW_ASSERT(a_done_spacing, clk, rst_n, done_reg |=> !done_reg, "back-to-back done")
    // cursor stays on screen between transactions
    `TTCW_ASSERT(a_cursor_range, clk, rst_n,
        (cursor_col_reg < 8'(SCREEN_COLS)) && (cursor_line_reg < 8'(SCREEN_ROWS)),
        "cursor off screen")
    // top pointer always names a real row
    `TTCW_ASSERT(a_top_range, clk, rst_n, top_reg < 8'(SCREEN_ROWS), "top row out of range")
    // a scroll is reported only with a result and while the blanking pass runs
    `TTCW_ASSERT(a_scroll_blank, clk, rst_n,
        scrolled_reg |-> (done_reg && state_reg == ttcw_pkg::ST_BLANK),
        "scroll without blanking pass")
    // no command is taken while the screen memory is being blanked
    `TTCW_NEVER(a_no_accept_blank, clk, rst_n,
        (state_reg == ttcw_pkg::ST_BLANK) && !busy, "idle during blanking")

endmodule
